[rtl/ubx_pkg.sv]
// ubx_pkg: shared types and codes for the binary gnss frame parser
// parser phases, register indexes, report kinds, config and result structs
// no dependencies
`timescale 1ns / 1ps

package ubx_pkg;

   // parser phases
   localparam logic [3:0] PH_SYNC1   = 4'd0;
   localparam logic [3:0] PH_SYNC2   = 4'd1;
   localparam logic [3:0] PH_CLASS   = 4'd2;
   localparam logic [3:0] PH_ID      = 4'd3;
   localparam logic [3:0] PH_LEN_LO  = 4'd4;
   localparam logic [3:0] PH_LEN_HI  = 4'd5;
   localparam logic [3:0] PH_PAYLOAD = 4'd6;
   localparam logic [3:0] PH_CHECK_A = 4'd7;
   localparam logic [3:0] PH_CHECK_B = 4'd8;

   // register indexes on the csr port
   localparam logic [1:0] REG_SYNC_FIRST   = 2'd0;
   localparam logic [1:0] REG_SYNC_SECOND  = 2'd1;
   localparam logic [1:0] REG_LENGTH_LIMIT = 2'd2;

   // reset values of the registers
   localparam logic [7:0]  SYNC_FIRST_RST   = 8'd181;
   localparam logic [7:0]  SYNC_SECOND_RST  = 8'd98;
   localparam logic [15:0] LENGTH_LIMIT_RST = 16'd1024;

   // report kinds
   localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
   localparam logic [1:0] KIND_GOOD      = 2'd1;
   localparam logic [1:0] KIND_BAD_SUM   = 2'd2;
   localparam logic [1:0] KIND_TOO_LONG  = 2'd3;

   typedef struct packed {
      logic [7:0]  sync_first;
      logic [7:0]  sync_second;
      logic [15:0] length_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [7:0]  payload_byte;
      logic [15:0] byte_index;
      logic [15:0] frame_length;
   } rsp_type;

endpackage

[rtl/ubx_csr.sv]
// ubx_csr: configuration registers (sync values and length limit)
// depends on ubx_pkg
`timescale 1ns / 1ps

module ubx_csr
   import ubx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   // register write decode; unknown index is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SYNC_FIRST:   cfg_in.sync_first   = csr_data[7:0];
            REG_SYNC_SECOND:  cfg_in.sync_second  = csr_data[7:0];
            REG_LENGTH_LIMIT: cfg_in.length_limit = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first   <= SYNC_FIRST_RST;
         cfg_ff.sync_second  <= SYNC_SECOND_RST;
         cfg_ff.length_limit <= LENGTH_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/ubx_core.sv]
// ubx_core: frame state machine, fletcher checksum and result register
// depends on ubx_pkg; configuration comes from ubx_csr
`timescale 1ns / 1ps

module ubx_core
   import ubx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_stall,
   input  logic [7:0] req_rx_byte,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  check_a_ff, check_a_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        load_ok;
   logic        accept;
   logic        res_valid;
   rsp_type     res;
   logic [7:0]  b;
   logic [7:0]  fa;
   logic [7:0]  fb;
   logic [15:0] len_new;
   logic [15:0] count_inc;

   // result register frees when empty or being taken
   assign load_ok   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !load_ok;
   assign accept    = req_valid && load_ok;

   assign b         = req_rx_byte;
   assign fa        = sum_a_ff + b;
   assign fb        = sum_b_ff + fa;
   assign len_new   = length_ff | {b, 8'd0};
   assign count_inc = count_ff + 16'd1;

   // next frame state and optional report for the current word
   always_comb begin
      phase_in   = phase_ff;
      class_in   = class_ff;
      id_in      = id_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      sum_a_in   = sum_a_ff;
      sum_b_in   = sum_b_ff;
      check_a_in = check_a_ff;
      res_valid  = 1'b0;
      res.kind         = KIND_PAYLOAD;
      res.msg_class    = class_ff;
      res.msg_id       = id_ff;
      res.payload_byte = 8'd0;
      res.byte_index   = 16'd0;
      res.frame_length = length_ff;
      case (phase_ff)
         PH_SYNC2: begin
            if (b == cfg.sync_second) begin
               phase_in = PH_CLASS;
            end else if (b == cfg.sync_first) begin
               phase_in = PH_SYNC2;
            end else begin
               phase_in = PH_SYNC1;
            end
         end
         PH_CLASS: begin
            class_in = b;
            sum_a_in = b;
            sum_b_in = b;
            phase_in = PH_ID;
         end
         PH_ID: begin
            id_in    = b;
            sum_a_in = fa;
            sum_b_in = fb;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {8'd0, b};
            sum_a_in  = fa;
            sum_b_in  = fb;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            sum_a_in = fa;
            sum_b_in = fb;
            count_in = 16'd0;
            if (len_new > cfg.length_limit) begin
               // oversize header: report and drop the frame
               res_valid        = 1'b1;
               res.kind         = KIND_TOO_LONG;
               res.frame_length = len_new;
               class_in   = 8'd0;
               id_in      = 8'd0;
               length_in  = 16'd0;
               sum_a_in   = 8'd0;
               sum_b_in   = 8'd0;
               check_a_in = 8'd0;
               phase_in   = (b == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
            end else begin
               length_in = len_new;
               phase_in  = (len_new == 16'd0) ? PH_CHECK_A : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = b;
            res.byte_index   = count_ff;
            sum_a_in = fa;
            sum_b_in = fb;
            count_in = count_inc;
            if (count_inc >= length_ff) begin
               phase_in = PH_CHECK_A;
            end
         end
         PH_CHECK_A: begin
            check_a_in = b;
            phase_in   = PH_CHECK_B;
         end
         PH_CHECK_B: begin
            res_valid = 1'b1;
            res.kind  = ((check_a_ff == sum_a_ff) && (b == sum_b_ff)) ?
                        KIND_GOOD : KIND_BAD_SUM;
            phase_in   = PH_SYNC1;
            class_in   = 8'd0;
            id_in      = 8'd0;
            length_in  = 16'd0;
            count_in   = 16'd0;
            sum_a_in   = 8'd0;
            sum_b_in   = 8'd0;
            check_a_in = 8'd0;
         end
         default: begin
            // hunting for the first sync byte
            if (b == cfg.sync_first) begin
               phase_in   = PH_SYNC2;
               class_in   = 8'd0;
               id_in      = 8'd0;
               length_in  = 16'd0;
               count_in   = 16'd0;
               sum_a_in   = 8'd0;
               sum_b_in   = 8'd0;
               check_a_in = 8'd0;
            end else begin
               phase_in = PH_SYNC1;
            end
         end
      endcase
   end

   // result register control
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load_ok) begin
         rsp_valid_in = accept && res_valid;
         if (accept && res_valid) begin
            rsp_in = res;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC1;
         class_ff     <= 8'd0;
         id_ff        <= 8'd0;
         length_ff    <= 16'd0;
         count_ff     <= 16'd0;
         sum_a_ff     <= 8'd0;
         sum_b_ff     <= 8'd0;
         check_a_ff   <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff   <= phase_in;
            class_ff   <= class_in;
            id_ff      <= id_in;
            length_ff  <= length_in;
            count_ff   <= count_in;
            sum_a_ff   <= sum_a_in;
            sum_b_ff   <= sum_b_in;
            check_a_ff <= check_a_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[rtl/ubx_frame_parser.sv]
// ubx_frame_parser: top level of the byte-serial binary gnss frame deframer
// depends on ubx_pkg, ubx_csr and ubx_core
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_rx_byte
//   rsp      out        rsp_valid/rsp_stall   rsp_kind .. rsp_frame_length
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// one word accepted per cycle while req_stall is low; a report appears in the cycle after its word
// the per-word state update and 8-bit checksum add sit before one result register
// req_stall is high only while a held report is stalled downstream
// synchronous reset returns to sync hunt and restores the register defaults
`timescale 1ns / 1ps

module ubx_frame_parser
   import ubx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_msg_class,
   output logic [7:0]  rsp_msg_id,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_byte_index,
   output logic [15:0] rsp_frame_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type cfg;
   rsp_type rsp;

   // configuration registers
   ubx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // parser and result register
   ubx_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp)
   );

   assign rsp_kind         = rsp.kind;
   assign rsp_msg_class    = rsp.msg_class;
   assign rsp_msg_id       = rsp.msg_id;
   assign rsp_payload_byte = rsp.payload_byte;
   assign rsp_byte_index   = rsp.byte_index;
   assign rsp_frame_length = rsp.frame_length;

endmodule

[dv/ubx_frame_parser_tb.sv]
// ubx_frame_parser_tb: self-checking bench for the byte-serial gnss frame parser
// streams frames, broken headers and noise under random idling; a scoreboard predicts reports
// depends on ubx_pkg and ubx_frame_parser
`timescale 1ns / 1ps

module ubx_frame_parser_tb;
   import ubx_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_WORDS   = 220;
   localparam int FILL_RANDOM   = -1;

   // checksum damage applied by the frame generator
   localparam logic [1:0] FLAW_NONE  = 2'd0;
   localparam logic [1:0] FLAW_SUM_A = 2'd1;
   localparam logic [1:0] FLAW_SUM_B = 2'd2;

   // predicts parser reports word by word and checks them in order
   class frame_scoreboard;
      cfg_type     cfg;
      logic [3:0]  phase;
      logic [7:0]  cls_q;
      logic [7:0]  id_q;
      logic [15:0] hdr_len;
      logic [15:0] pay_count;
      logic [7:0]  fl_a;
      logic [7:0]  fl_b;
      logic [7:0]  check_a_seen;
      rsp_type     expected_q[$];
      int          errors;
      int          n_payload, n_good, n_bad, n_long;

      function new();
         cfg.sync_first   = SYNC_FIRST_RST;
         cfg.sync_second  = SYNC_SECOND_RST;
         cfg.length_limit = LENGTH_LIMIT_RST;
         clear_frame();
      endfunction

      function void clear_frame();
         phase        = PH_SYNC1;
         cls_q        = '0;
         id_q         = '0;
         hdr_len      = '0;
         pay_count    = '0;
         fl_a         = '0;
         fl_b         = '0;
         check_a_seen = '0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] data);
         case (idx)
            REG_SYNC_FIRST:   cfg.sync_first = data[7:0];
            REG_SYNC_SECOND:  cfg.sync_second = data[7:0];
            REG_LENGTH_LIMIT: cfg.length_limit = data;
            default: ;
         endcase
      endfunction

      function void fold(logic [7:0] b);
         fl_a = fl_a + b;
         fl_b = fl_b + fl_a;
      endfunction

      function rsp_type make_report(logic [1:0] k, logic [7:0] d, logic [15:0] idx);
         rsp_type r;
         r.kind         = k;
         r.msg_class    = cls_q;
         r.msg_id       = id_q;
         r.payload_byte = d;
         r.byte_index   = idx;
         r.frame_length = hdr_len;
         return r;
      endfunction

      // append one prediction at the tail
      function void queue_report(rsp_type r);
         expected_q = {expected_q, r};
      endfunction

      // advance the parser by one accepted word
      function void note_word(logic [7:0] b);
         case (phase)
            PH_SYNC2: begin
               if (b == cfg.sync_second) phase = PH_CLASS;
               else if (b == cfg.sync_first) phase = PH_SYNC2;
               else phase = PH_SYNC1;
            end
            PH_CLASS: begin
               cls_q = b;
               fl_a  = '0;
               fl_b  = '0;
               fold(b);
               phase = PH_ID;
            end
            PH_ID: begin
               id_q = b;
               fold(b);
               phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               hdr_len = {8'h00, b};
               fold(b);
               phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               hdr_len[15:8] = b;
               fold(b);
               pay_count = '0;
               if (hdr_len > cfg.length_limit) begin
                  queue_report(make_report(KIND_TOO_LONG, 8'h00, 16'h0000));
                  clear_frame();
                  // an oversize high byte that looks like a sync restarts the hunt midway
                  if (b == cfg.sync_first) phase = PH_SYNC2;
               end else begin
                  phase = (hdr_len == 16'h0000) ? PH_CHECK_A : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               queue_report(make_report(KIND_PAYLOAD, b, pay_count));
               fold(b);
               pay_count = pay_count + 16'd1;
               if (pay_count >= hdr_len) phase = PH_CHECK_A;
            end
            PH_CHECK_A: begin
               check_a_seen = b;
               phase = PH_CHECK_B;
            end
            PH_CHECK_B: begin
               if (check_a_seen == fl_a && b == fl_b)
                  queue_report(make_report(KIND_GOOD, 8'h00, 16'h0000));
               else
                  queue_report(make_report(KIND_BAD_SUM, 8'h00, 16'h0000));
               clear_frame();
            end
            default: begin
               if (b == cfg.sync_first) begin
                  clear_frame();
                  phase = PH_SYNC2;
               end else begin
                  phase = PH_SYNC1;
               end
            end
         endcase
      endfunction

      function void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
         if (exp_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
         end
      endfunction

      // compare one delivered report against the oldest prediction
      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected report: kind %0d class %0d id %0d", got.kind, got.msg_class,
                   got.msg_id);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("kind", 16'(want.kind), 16'(got.kind));
         compare_field("msg_class", 16'(want.msg_class), 16'(got.msg_class));
         compare_field("msg_id", 16'(want.msg_id), 16'(got.msg_id));
         compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
         compare_field("byte_index", want.byte_index, got.byte_index);
         compare_field("frame_length", want.frame_length, got.frame_length);
         case (want.kind)
            KIND_PAYLOAD:  n_payload++;
            KIND_GOOD:     n_good++;
            KIND_BAD_SUM:  n_bad++;
            default:       n_long++;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_msg_class;
   logic [7:0]  rsp_msg_id;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_byte_index;
   logic [15:0] rsp_frame_length;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_SYNC_FIRST;
   logic [15:0] csr_data = 16'h0000;

   frame_scoreboard sb;
   cfg_type         cur_cfg;
   bit              quiet = 1'b0;
   int              burst_left = 0;
   int              stall_left = 0;
   bit              stall_on = 1'b0;
   int              words_sent = 0;
   int              settings_run = 0;
   int              cycle_count = 0;

   ubx_frame_parser uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_msg_class    (rsp_msg_class),
      .rsp_msg_id       (rsp_msg_id),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #4 clock = ~clock;

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver stalls in runs of random length; quiet stretches never stall
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_left = $urandom_range(1, 8);
         stall_on = !quiet && ($urandom_range(0, 2) == 0);
      end
      stall_left--;
      rsp_stall = stall_on;
   end

   // report monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_kind, rsp_msg_class, rsp_msg_id, rsp_payload_byte,
                          rsp_byte_index, rsp_frame_length});
   end

   // send one word, inserting a gap between bursts outside quiet stretches
   task automatic put_word(input logic [7:0] b);
      if (burst_left == 0) begin
         if (!quiet) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid = 1'b1;
      req_rx_byte = b;
      do @(posedge clock); while (req_stall);
      sb.note_word(b);
      words_sent++;
      @(negedge clock);
   endtask

   // hold off until every predicted report is out, then let the pipe settle
   task automatic wait_drain();
      int guard;
      req_valid = 1'b0;
      guard = 0;
      while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // new register setting, written only with the parser idle
   task automatic apply_config(input logic [7:0] s1, input logic [7:0] s2,
                               input logic [15:0] lim, input logic [7:0] pad);
      wait_drain();
      csr_write(REG_SYNC_FIRST, {pad, s1});
      csr_write(REG_SYNC_SECOND, {~pad, s2});
      csr_write(REG_LENGTH_LIMIT, lim);
      cur_cfg.sync_first = s1;
      cur_cfg.sync_second = s2;
      cur_cfg.length_limit = lim;
      settings_run++;
   endtask

   // complete frame with optional repeated first sync and damaged checksum
   task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input int n_sync,
                             input logic [1:0] flaw, input int fill);
      logic [7:0] body[$];
      logic [7:0] ck_a;
      logic [7:0] ck_b;
      body = {body, cls};
      body = {body, id};
      body = {body, len[7:0]};
      body = {body, len[15:8]};
      repeat (len) body = {body, ((fill < 0) ? 8'($urandom) : 8'(fill))};
      ck_a = 8'h00;
      ck_b = 8'h00;
      foreach (body[i]) begin
         ck_a = ck_a + body[i];
         ck_b = ck_b + ck_a;
      end
      if (flaw == FLAW_SUM_A) ck_a = ck_a ^ 8'($urandom_range(1, 255));
      if (flaw == FLAW_SUM_B) ck_b = ck_b ^ 8'($urandom_range(1, 255));
      repeat (n_sync) put_word(cur_cfg.sync_first);
      put_word(cur_cfg.sync_second);
      foreach (body[i]) put_word(body[i]);
      put_word(ck_a);
      put_word(ck_b);
   endtask

   task automatic send_oversize(input logic [15:0] len);
      put_word(cur_cfg.sync_first);
      put_word(cur_cfg.sync_second);
      put_word(8'($urandom));
      put_word(8'($urandom));
      put_word(len[7:0]);
      put_word(len[15:8]);
   endtask

   // mostly short payloads, now and then the limit itself or a longer one
   function automatic logic [15:0] pick_len();
      int cap;
      cap = (cur_cfg.length_limit < 24) ? cur_cfg.length_limit : 24;
      case ($urandom_range(0, 19))
         0: return (cur_cfg.length_limit <= 200) ? cur_cfg.length_limit : 16'd200;
         1: return 16'($urandom_range(0, (cur_cfg.length_limit < 120) ?
                                         cur_cfg.length_limit : 120));
         default: return 16'($urandom_range(0, cap));
      endcase
   endfunction

   // length above the limit, often with a high byte equal to the first sync
   function automatic logic [15:0] pick_oversize();
      logic [15:0] v;
      v = {cur_cfg.sync_first, 8'($urandom)};
      if ($urandom_range(0, 1) == 0 || v <= cur_cfg.length_limit)
         v = 16'($urandom_range(65535, cur_cfg.length_limit + 1));
      return v;
   endfunction

   task automatic run_random(input int count);
      int stop_at;
      int pick;
      int n_sync;
      int f;
      logic [1:0] flaw;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 29) == 0) quiet = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            n_sync = 1;
            if (cur_cfg.sync_first != cur_cfg.sync_second && $urandom_range(0, 5) == 0)
               n_sync = $urandom_range(2, 4);
            f = $urandom_range(0, 9);
            flaw = (f == 0) ? FLAW_SUM_A : (f == 1) ? FLAW_SUM_B : FLAW_NONE;
            send_frame(8'($urandom), 8'($urandom), pick_len(), n_sync, flaw, FILL_RANDOM);
         end else if (pick < 75 && cur_cfg.length_limit != 16'hFFFF) begin
            send_oversize(pick_oversize());
         end else if (pick < 87) begin
            // first sync followed by a stray word
            put_word(cur_cfg.sync_first);
            put_word(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 4)) put_word(8'($urandom));
         end
         if ($urandom_range(0, 39) == 0) wait_drain();
      end
   endtask

   initial begin
      sb = new();
      cur_cfg.sync_first = SYNC_FIRST_RST;
      cur_cfg.sync_second = SYNC_SECOND_RST;
      cur_cfg.length_limit = LENGTH_LIMIT_RST;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: noise, repeated sync, field extremes, bad checksum, broken sync,
      // oversize header whose high byte is the first sync
      put_word(8'h00);
      put_word(8'hFF);
      send_frame(8'hFF, 8'h00, 16'd1, 2, FLAW_NONE, 8'hFF);
      send_frame(8'h00, 8'hFF, 16'd0, 1, FLAW_SUM_B, 8'h00);
      put_word(cur_cfg.sync_first);
      put_word(8'h00);
      send_oversize({SYNC_FIRST_RST, 8'h00});

      // random traffic under a series of register settings
      run_random(PHASE_WORDS);
      apply_config(8'h00, 8'hFF, 16'd0, 8'h00);
      run_random(PHASE_WORDS);
      apply_config(8'hFF, 8'h00, 16'hFFFF, 8'hFF);
      run_random(PHASE_WORDS);
      apply_config(8'h5A, 8'h5A, 16'd16, 8'h00);
      run_random(PHASE_WORDS);
      apply_config(8'($urandom), 8'($urandom), 16'($urandom_range(0, 40)), 8'($urandom));
      run_random(PHASE_WORDS);
      apply_config(SYNC_FIRST_RST, SYNC_SECOND_RST, LENGTH_LIMIT_RST, 8'h00);
      run_random(PHASE_WORDS);

      wait_drain();
      if (sb.pending() != 0) begin
         $error("%0d predicted reports never arrived", sb.pending());
         sb.errors++;
      end
      $display("covered %0d input words over %0d register settings", words_sent,
               settings_run + 1);
      $display("reports: %0d payload, %0d good frames, %0d bad checksums, %0d oversize",
               sb.n_payload, sb.n_good, sb.n_bad, sb.n_long);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
